FILE: rtl/mfmc_pkg.sv
// ----------------------------------------------------------------------------
// mfmc_pkg
// Shared widths, codes and controller/datapath bundles of the max-flow core.
// ----------------------------------------------------------------------------
package mfmc_pkg;

    localparam int MAX_NODES_DEF = 64;
    localparam int CAP_BITS_DEF  = 48;

    localparam int NODE_W     = 6;
    localparam int CNT_W      = 7;
    localparam int FLOW_W     = 56;
    localparam int WEIGHT_W   = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam logic [FLOW_W-1:0] FLOW_MAX = '1;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SINK       = 2'd2;

    // capacity write data select
    typedef enum logic [1:0] {
        WR_ZERO,
        WR_ADD_WEIGHT,
        WR_SUB_NECK,
        WR_ADD_NECK
    } t_cap_wsel;

    typedef struct packed {
        logic              w_load;
        logic              cap_we;
        t_cap_wsel         cap_wsel;
        logic              par_we;
        logic [NODE_W-1:0] par_raddr;
        logic [NODE_W-1:0] par_waddr;
        logic [NODE_W-1:0] par_wdata;
        logic              q_we;
        logic [NODE_W-1:0] q_raddr;
        logic [NODE_W-1:0] q_waddr;
        logic [NODE_W-1:0] q_wdata;
        logic              vis_clear;
        logic              vis_set;
        logic [NODE_W-1:0] vis_idx;
        logic              neck_init;
        logic              neck_min;
        logic              flow_clear;
        logic              flow_add;
        logic              cnt_clear;
        logic              cnt_inc;
    } t_dp_cmd;

    typedef struct packed {
        logic              cap_nz;
        logic              vis_bit;
        logic [NODE_W-1:0] par_rdata;
        logic [NODE_W-1:0] q_rdata;
        logic [CNT_W-1:0]  cnt;
        logic [FLOW_W-1:0] flow;
    } t_dp_sts;

endpackage

FILE: rtl/mfmc_ram.sv
// ----------------------------------------------------------------------------
// mfmc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mfmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mfmc_dpath.sv
// ----------------------------------------------------------------------------
// mfmc_dpath
// Datapath: capacity matrix, parent and queue memories, visited marks,
// bottleneck, flow total and cut-size counter.
// ----------------------------------------------------------------------------
module mfmc_dpath import mfmc_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int CAP_BITS  = CAP_BITS_DEF,
    localparam int LIM = (MAX_NODES < 64) ? MAX_NODES : 64,
    localparam int LW  = $clog2(LIM),
    localparam int D   = MAX_NODES * MAX_NODES,
    localparam int AW  = $clog2(D)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [AW-1:0]       i_cap_raddr,
    input  logic [AW-1:0]       i_cap_waddr,
    input  logic [WEIGHT_W-1:0] i_weight,
    output t_dp_sts             o_sts
);

    localparam int SW  = ((CAP_BITS > WEIGHT_W) ? CAP_BITS : WEIGHT_W) + 1;
    localparam int FSW = ((FLOW_W > CAP_BITS) ? FLOW_W : CAP_BITS) + 1;
    localparam logic [CAP_BITS-1:0] INFLL = '1;

    logic [CAP_BITS-1:0] w_cap_rd;
    logic [CAP_BITS-1:0] w_cap_wd;
    logic [SW-1:0]       w_sum_w;
    logic [CAP_BITS:0]   w_sum_n;
    logic [FSW-1:0]      w_sum_f;
    logic [NODE_W-1:0]   w_par_rd;
    logic [NODE_W-1:0]   w_q_rd;
    logic                w_vis_ok;

    logic [LIM-1:0]      r_vis;
    logic [LIM-1:0]      n_vis;
    logic [CAP_BITS-1:0] r_neck;
    logic [FLOW_W-1:0]   r_flow;
    logic [CNT_W-1:0]    r_cnt;
    logic [WEIGHT_W-1:0] r_weight;

    mfmc_ram #(.WIDTH(CAP_BITS), .DEPTH(D)) u_cap (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cap_we),
        .i_waddr (i_cap_waddr),
        .i_wdata (w_cap_wd),
        .i_raddr (i_cap_raddr),
        .o_rdata (w_cap_rd)
    );

    mfmc_ram #(.WIDTH(NODE_W), .DEPTH(LIM)) u_par (
        .i_clk   (i_clk),
        .i_we    (i_cmd.par_we),
        .i_waddr (i_cmd.par_waddr[LW-1:0]),
        .i_wdata (i_cmd.par_wdata),
        .i_raddr (i_cmd.par_raddr[LW-1:0]),
        .o_rdata (w_par_rd)
    );

    mfmc_ram #(.WIDTH(NODE_W), .DEPTH(LIM)) u_queue (
        .i_clk   (i_clk),
        .i_we    (i_cmd.q_we),
        .i_waddr (i_cmd.q_waddr[LW-1:0]),
        .i_wdata (i_cmd.q_wdata),
        .i_raddr (i_cmd.q_raddr[LW-1:0]),
        .o_rdata (w_q_rd)
    );

    // saturating sums for capacity updates and the flow total
    assign w_sum_w = SW'(w_cap_rd) + SW'(r_weight);
    assign w_sum_n = {1'b0, w_cap_rd} + {1'b0, r_neck};
    assign w_sum_f = FSW'(r_flow) + FSW'(r_neck);

    always_comb begin
        unique case (i_cmd.cap_wsel)
            WR_ZERO:       w_cap_wd = '0;
            WR_ADD_WEIGHT: w_cap_wd = (w_sum_w > SW'(INFLL)) ? INFLL : w_sum_w[CAP_BITS-1:0];
            WR_SUB_NECK:   w_cap_wd = w_cap_rd - r_neck;
            WR_ADD_NECK:   w_cap_wd = w_sum_n[CAP_BITS] ? INFLL : w_sum_n[CAP_BITS-1:0];
            default:       w_cap_wd = '0;
        endcase
    end

    // visited marks: clear, then set one node
    assign w_vis_ok = ({1'b0, i_cmd.vis_idx} < CNT_W'(LIM));

    always_comb begin
        n_vis = i_cmd.vis_clear ? '0 : r_vis;
        if (i_cmd.vis_set && w_vis_ok) begin
            n_vis[i_cmd.vis_idx[LW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vis  <= '0;
            r_flow <= '0;
            r_cnt  <= '0;
        end else begin
            r_vis <= n_vis;
            if (i_cmd.flow_clear) begin
                r_flow <= '0;
            end else if (i_cmd.flow_add) begin
                r_flow <= (w_sum_f > FSW'(FLOW_MAX)) ? FLOW_MAX : w_sum_f[FLOW_W-1:0];
            end
            if (i_cmd.cnt_clear) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // payload: bottleneck and latched edge weight
    always_ff @(posedge i_clk) begin
        if (i_cmd.neck_init) begin
            r_neck <= INFLL;
        end else if (i_cmd.neck_min && (w_cap_rd < r_neck)) begin
            r_neck <= w_cap_rd;
        end
        if (i_cmd.w_load) begin
            r_weight <= i_weight;
        end
    end

    assign o_sts.cap_nz    = |w_cap_rd;
    assign o_sts.vis_bit   = w_vis_ok ? r_vis[i_cmd.vis_idx[LW-1:0]] : 1'b0;
    assign o_sts.par_rdata = w_par_rd;
    assign o_sts.q_rdata   = w_q_rd;
    assign o_sts.cnt       = r_cnt;
    assign o_sts.flow      = r_flow;

endmodule

FILE: rtl/mfmc_ctrl.sv
// ----------------------------------------------------------------------------
// mfmc_ctrl
// Controller: edge loading, breadth-first search, path augmentation,
// cut emission and matrix clearing, plus configuration registers.
// ----------------------------------------------------------------------------
module mfmc_ctrl import mfmc_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF,
    localparam int LIM = (MAX_NODES < 64) ? MAX_NODES : 64,
    localparam int D   = MAX_NODES * MAX_NODES,
    localparam int AW  = $clog2(D)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [71:0]           m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_dp_cmd               o_cmd,
    output logic [AW-1:0]         o_cap_raddr,
    output logic [AW-1:0]         o_cap_waddr,
    input  t_dp_sts               i_sts
);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_EDGE_RD, S_EDGE_WR, S_RUN, S_SINGLE,
        S_BFS_INIT, S_BFS_POP, S_BFS_U, S_BFS_SCAN, S_BFS_DONE,
        S_W1_PAR, S_W1_CAP, S_W1_MIN,
        S_W2_PAR, S_W2_RD1, S_W2_WR1, S_W2_WR2,
        S_CNT, S_EMIT, S_WAIT
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_n, n_n;
    logic [NODE_W-1:0] r_from, n_from;
    logic [NODE_W-1:0] r_to, n_to;
    logic [NODE_W-1:0] r_u, n_u;
    logic [CNT_W-1:0]  r_v, n_v;
    logic [NODE_W-1:0] r_vd, n_vd;
    logic              r_pend, n_pend;
    logic [CNT_W-1:0]  r_head, n_head;
    logic [CNT_W-1:0]  r_tail, n_tail;
    logic [NODE_W-1:0] r_wv, n_wv;
    logic [NODE_W-1:0] r_p, n_p;
    logic [AW-1:0]     r_clr, n_clr;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_k, n_k;
    logic [CNT_W-1:0]  r_node_count, n_node_count;
    logic [NODE_W-1:0] r_src, n_src;
    logic [NODE_W-1:0] r_dst, n_dst;
    logic              r_tvalid, n_tvalid;
    logic [NODE_W-1:0] r_cut, n_cut;
    logic              r_last, n_last;
    logic [CNT_W-1:0]  r_size, n_size;
    logic [FLOW_W-1:0] r_flow, n_flow;

    logic [CNT_W-1:0]  w_n_clamp;

    // matrix address of entry (a, b)
    function automatic logic [AW-1:0] f_addr(input logic [NODE_W-1:0] a,
                                             input logic [NODE_W-1:0] b);
        return AW'(AW'(a) * AW'(MAX_NODES)) + AW'(b);
    endfunction

    // clamp the node count to the usable range
    always_comb begin
        if (r_node_count < CNT_W'(2)) begin
            w_n_clamp = CNT_W'(2);
        end else if (r_node_count > CNT_W'(LIM)) begin
            w_n_clamp = CNT_W'(LIM);
        end else begin
            w_n_clamp = r_node_count;
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_from       = r_from;
        n_to         = r_to;
        n_u          = r_u;
        n_v          = r_v;
        n_vd         = r_vd;
        n_pend       = r_pend;
        n_head       = r_head;
        n_tail       = r_tail;
        n_wv         = r_wv;
        n_p          = r_p;
        n_clr        = r_clr;
        n_idx        = r_idx;
        n_k          = r_k;
        n_node_count = r_node_count;
        n_src        = r_src;
        n_dst        = r_dst;
        n_tvalid     = r_tvalid & ~m_axis_tready;
        n_cut        = r_cut;
        n_last       = r_last;
        n_size       = r_size;
        n_flow       = r_flow;
        o_cmd        = '0;
        o_cap_raddr  = '0;
        o_cap_waddr  = '0;

        // configuration words
        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_NODE_COUNT) begin
                n_node_count = i_cfg_data;
            end else if (i_cfg_index == CFG_SOURCE) begin
                n_src = i_cfg_data[NODE_W-1:0];
            end else if (i_cfg_index == CFG_SINK) begin
                n_dst = i_cfg_data[NODE_W-1:0];
            end
        end

        unique case (r_state)
            // zero the matrix one entry a cycle
            S_CLEAR: begin
                o_cmd.cap_we     = 1'b1;
                o_cmd.cap_wsel   = WR_ZERO;
                o_cmd.flow_clear = 1'b1;
                o_cap_waddr      = r_clr;
                if (r_clr == AW'(D - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_from       = s_axis_tdata[5:0];
                    n_to         = s_axis_tdata[11:6];
                    o_cmd.w_load = 1'b1;
                    if (s_axis_tuser[0] == OP_RUN) begin
                        n_state = S_RUN;
                    end else if (({1'b0, s_axis_tdata[5:0]} < CNT_W'(LIM)) &&
                                 ({1'b0, s_axis_tdata[11:6]} < CNT_W'(LIM))) begin
                        n_state = S_EDGE_RD;
                    end
                end
            end
            S_EDGE_RD: begin
                o_cap_raddr = f_addr(r_from, r_to);
                n_state     = S_EDGE_WR;
            end
            S_EDGE_WR: begin
                o_cmd.cap_we   = 1'b1;
                o_cmd.cap_wsel = WR_ADD_WEIGHT;
                o_cap_waddr    = f_addr(r_from, r_to);
                n_state        = S_IDLE;
            end
            S_RUN: begin
                n_n              = w_n_clamp;
                o_cmd.flow_clear = 1'b1;
                if (({1'b0, r_src} >= w_n_clamp) || (r_src == r_dst)) begin
                    n_state = S_SINGLE;
                end else begin
                    n_state = S_BFS_INIT;
                end
            end
            // degenerate run: only the source, no flow
            S_SINGLE: begin
                n_tvalid = 1'b1;
                n_cut    = r_src;
                n_last   = 1'b1;
                n_size   = CNT_W'(1);
                n_flow   = '0;
                n_idx    = r_n;
                n_state  = S_WAIT;
            end
            S_BFS_INIT: begin
                o_cmd.vis_clear = 1'b1;
                o_cmd.vis_set   = 1'b1;
                o_cmd.vis_idx   = r_src;
                o_cmd.q_we      = 1'b1;
                o_cmd.q_waddr   = '0;
                o_cmd.q_wdata   = r_src;
                n_head          = '0;
                n_tail          = CNT_W'(1);
                n_state         = S_BFS_POP;
            end
            S_BFS_POP: begin
                if (r_head == r_tail) begin
                    n_state = S_BFS_DONE;
                end else begin
                    o_cmd.q_raddr = r_head[NODE_W-1:0];
                    n_head        = r_head + 1'b1;
                    n_state       = S_BFS_U;
                end
            end
            S_BFS_U: begin
                n_u     = i_sts.q_rdata;
                n_v     = '0;
                n_pend  = 1'b0;
                n_state = S_BFS_SCAN;
            end
            // issue one row read a cycle, test the word that returns
            S_BFS_SCAN: begin
                if (r_v < r_n) begin
                    o_cap_raddr = f_addr(r_u, r_v[NODE_W-1:0]);
                    n_v         = r_v + 1'b1;
                    n_vd        = r_v[NODE_W-1:0];
                    n_pend      = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    o_cmd.vis_idx = r_vd;
                    if (i_sts.cap_nz && !i_sts.vis_bit) begin
                        o_cmd.vis_set   = 1'b1;
                        o_cmd.par_we    = 1'b1;
                        o_cmd.par_waddr = r_vd;
                        o_cmd.par_wdata = r_u;
                        o_cmd.q_we      = 1'b1;
                        o_cmd.q_waddr   = r_tail[NODE_W-1:0];
                        o_cmd.q_wdata   = r_vd;
                        n_tail          = r_tail + 1'b1;
                    end
                end
                if (!(r_v < r_n) && !r_pend) begin
                    n_state = S_BFS_POP;
                end
            end
            S_BFS_DONE: begin
                o_cmd.vis_idx   = r_dst;
                o_cmd.cnt_clear = 1'b1;
                if (({1'b0, r_dst} < r_n) && i_sts.vis_bit) begin
                    o_cmd.neck_init = 1'b1;
                    n_wv            = r_dst;
                    n_state         = S_W1_PAR;
                end else begin
                    n_idx   = '0;
                    n_state = S_CNT;
                end
            end
            // first walk: bottleneck along the path
            S_W1_PAR: begin
                if (r_wv == r_src) begin
                    n_wv    = r_dst;
                    n_state = S_W2_PAR;
                end else begin
                    o_cmd.par_raddr = r_wv;
                    n_state         = S_W1_CAP;
                end
            end
            S_W1_CAP: begin
                n_p         = i_sts.par_rdata;
                o_cap_raddr = f_addr(i_sts.par_rdata, r_wv);
                n_state     = S_W1_MIN;
            end
            S_W1_MIN: begin
                o_cmd.neck_min = 1'b1;
                n_wv           = r_p;
                n_state        = S_W1_PAR;
            end
            // second walk: update forward and reverse residuals
            S_W2_PAR: begin
                if (r_wv == r_src) begin
                    o_cmd.flow_add = 1'b1;
                    n_state        = S_BFS_INIT;
                end else begin
                    o_cmd.par_raddr = r_wv;
                    n_state         = S_W2_RD1;
                end
            end
            S_W2_RD1: begin
                n_p         = i_sts.par_rdata;
                o_cap_raddr = f_addr(i_sts.par_rdata, r_wv);
                n_state     = S_W2_WR1;
            end
            S_W2_WR1: begin
                o_cmd.cap_we   = 1'b1;
                o_cmd.cap_wsel = WR_SUB_NECK;
                o_cap_waddr    = f_addr(r_p, r_wv);
                o_cap_raddr    = f_addr(r_wv, r_p);
                n_state        = S_W2_WR2;
            end
            S_W2_WR2: begin
                o_cmd.cap_we   = 1'b1;
                o_cmd.cap_wsel = WR_ADD_NECK;
                o_cap_waddr    = f_addr(r_wv, r_p);
                n_wv           = r_p;
                n_state        = S_W2_PAR;
            end
            // count the source side
            S_CNT: begin
                o_cmd.vis_idx = r_idx[NODE_W-1:0];
                if (r_idx < r_n) begin
                    o_cmd.cnt_inc = i_sts.vis_bit;
                    n_idx         = r_idx + 1'b1;
                end else begin
                    n_idx   = '0;
                    n_k     = '0;
                    n_state = S_EMIT;
                end
            end
            // emit source-side nodes in increasing order
            S_EMIT: begin
                o_cmd.vis_idx = r_idx[NODE_W-1:0];
                if (r_idx >= r_n) begin
                    n_clr   = '0;
                    n_state = S_CLEAR;
                end else begin
                    n_idx = r_idx + 1'b1;
                    if (i_sts.vis_bit) begin
                        n_tvalid = 1'b1;
                        n_cut    = r_idx[NODE_W-1:0];
                        n_last   = ((r_k + 1'b1) == i_sts.cnt);
                        n_size   = i_sts.cnt;
                        n_flow   = i_sts.flow;
                        n_k      = r_k + 1'b1;
                        n_state  = S_WAIT;
                    end
                end
            end
            // hold until the word is taken
            S_WAIT: begin
                if (m_axis_tready) begin
                    n_state = S_EMIT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_pend       <= 1'b0;
            r_tvalid     <= 1'b0;
            r_node_count <= CNT_W'(64);
            r_src        <= NODE_W'(0);
            r_dst        <= NODE_W'(1);
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_pend       <= n_pend;
            r_tvalid     <= n_tvalid;
            r_node_count <= n_node_count;
            r_src        <= n_src;
            r_dst        <= n_dst;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_from <= n_from;
        r_to   <= n_to;
        r_u    <= n_u;
        r_v    <= n_v;
        r_vd   <= n_vd;
        r_head <= n_head;
        r_tail <= n_tail;
        r_wv   <= n_wv;
        r_p    <= n_p;
        r_idx  <= n_idx;
        r_k    <= n_k;
        r_cut  <= n_cut;
        r_last <= n_last;
        r_size <= n_size;
        r_flow <= n_flow;
    end

    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tlast  = r_last;
    assign m_axis_tdata  = {3'b000, r_flow, r_size, r_cut};

endmodule

FILE: rtl/max_flow_min_cut_core.sv
// ----------------------------------------------------------------------------
// max_flow_min_cut_core
// Edmonds-Karp maximum flow with minimum-cut output over a capacity matrix.
// ----------------------------------------------------------------------------
// Edge words (tuser op 0) add a saturating capacity by a read-modify-write
// of the single-port-pair matrix RAM. A run word (op 1) holds the input for
// the whole computation: every search pass reads the row of each popped node
// one entry a cycle, and each augmenting path then updates the residuals
// along it. The source-side nodes then leave one word each, after a counting
// sweep. After reset and after every run the matrix is zeroed one entry a
// cycle, MAX_NODES * MAX_NODES entries (4096 at the defaults), during which
// no word is accepted; configuration writes are taken at all times.
module max_flow_min_cut_core import mfmc_pkg::*; #(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int CAP_BITS  = CAP_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [47:0]           s_axis_tdata,  // from_node, to_node, weight
    input  logic [0:0]            s_axis_tuser,  // op
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [71:0]           m_axis_tdata,  // cut_node, cut_size, total_flow
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(MAX_NODES * MAX_NODES);

    t_dp_cmd       w_cmd;
    t_dp_sts       w_sts;
    logic [AW-1:0] w_cap_raddr;
    logic [AW-1:0] w_cap_waddr;

    mfmc_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_cmd         (w_cmd),
        .o_cap_raddr   (w_cap_raddr),
        .o_cap_waddr   (w_cap_waddr),
        .i_sts         (w_sts)
    );

    mfmc_dpath #(.MAX_NODES(MAX_NODES), .CAP_BITS(CAP_BITS)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cap_raddr (w_cap_raddr),
        .i_cap_waddr (w_cap_waddr),
        .i_weight    (s_axis_tdata[43:12]),
        .o_sts       (w_sts)
    );

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for max_flow_min_cut_core: loads random and directed
// graphs, runs max flow, and checks every minimum-cut word against an
// in-bench Edmonds-Karp predictor.
// ----------------------------------------------------------------------------
module testbench;
    import mfmc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NN = 64;
    localparam logic [47:0] CAP_TOP = '1;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic              last;
        logic [CNT_W-1:0]  size;
        logic [FLOW_W-1:0] flow;
    } t_cut_word;

    // Scoreboard: predicts cut words for each accepted input word
    class cut_scoreboard;
        logic [47:0]       cap [NN*NN];
        logic [CNT_W-1:0]  cfg_count;
        logic [NODE_W-1:0] cfg_src;
        logic [NODE_W-1:0] cfg_sink;
        t_cut_word         pending[$];
        int                errors;

        function new();
            foreach (cap[i]) cap[i] = '0;
            cfg_count = 7'd64;
            cfg_src = '0;
            cfg_sink = 6'd1;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_NODE_COUNT) cfg_count = val;
            else if (idx == CFG_SOURCE) cfg_src = val[NODE_W-1:0];
            else if (idx == CFG_SINK) cfg_sink = val[NODE_W-1:0];
        endfunction

        // Append one predicted word at the tail
        function void queue_word(t_cut_word w);
            pending = {pending, w};
        endfunction

        // Breadth-first search from s over nonzero residuals; fills par
        function void bfs(int s, int n, ref bit seen[NN], ref int par[NN]);
            int q[NN];
            int head;
            int tail;
            int u;
            foreach (seen[i]) seen[i] = 0;
            seen[s] = 1;
            q[0] = s;
            head = 0;
            tail = 1;
            while (head < tail) begin
                u = q[head];
                head++;
                for (int v = 0; v < n; v++) begin
                    if (cap[u*NN+v] != 0 && !seen[v]) begin
                        seen[v] = 1;
                        par[v] = u;
                        if (tail < NN) begin
                            q[tail] = v;
                            tail++;
                        end
                    end
                end
            end
        endfunction

        function void note_input(logic op, logic [5:0] a, logic [5:0] b, logic [31:0] w);
            bit   seen[NN];
            int   par[NN];
            int   n, s, t, cnt, k;
            logic [47:0] neck;
            logic [56:0] flow;
            logic [48:0] sum;
            if (op == OP_EDGE) begin
                sum = {1'b0, cap[a*NN+b]} + w;
                cap[a*NN+b] = sum[48] ? CAP_TOP : sum[47:0];
                return;
            end
            n = cfg_count < 2 ? 2 : (cfg_count > NN ? NN : cfg_count);
            s = cfg_src;
            t = cfg_sink;
            flow = '0;
            if (s >= n || s == t) begin
                queue_word('{node: cfg_src, last: 1'b1, size: 7'd1, flow: '0});
            end else begin
                forever begin
                    bfs(s, n, seen, par);
                    if (!seen[t]) break;
                    neck = CAP_TOP;
                    for (int v = t; v != s; v = par[v])
                        if (cap[par[v]*NN+v] < neck) neck = cap[par[v]*NN+v];
                    for (int v = t; v != s; v = par[v]) begin
                        cap[par[v]*NN+v] -= neck;
                        sum = {1'b0, cap[v*NN+par[v]]} + neck;
                        cap[v*NN+par[v]] = sum[48] ? CAP_TOP : sum[47:0];
                    end
                    flow = flow + neck;
                    if (flow[56]) flow = {1'b0, FLOW_MAX};
                end
                bfs(s, n, seen, par);
                cnt = 0;
                for (int u = 0; u < n; u++) cnt += seen[u];
                k = 0;
                for (int u = 0; u < n; u++) begin
                    if (!seen[u]) continue;
                    k++;
                    queue_word('{node: u[5:0], last: k == cnt, size: cnt[6:0],
                                 flow: flow[55:0]});
                end
            end
            foreach (cap[i]) cap[i] = '0;
        endfunction

        function void report(string what, logic [63:0] got, logic [63:0] want);
            $display("cut word %s: got %0d, expected %0d", what, got, want);
            errors++;
        endfunction

        function void check_result(t_cut_word got);
            t_cut_word want;
            if (pending.size() == 0) begin
                $display("cut word %0d arrived with nothing predicted", got.node);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.node !== want.node) report("node", got.node, want.node);
            if (got.last !== want.last) report("last", got.last, want.last);
            if (got.size !== want.size) report("size", got.size, want.size);
            if (got.flow !== want.flow) report("flow", got.flow, want.flow);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [47:0]           s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [71:0]           m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    cut_scoreboard sb = new();
    int burst_left = 0;
    bit stall_mode = 0;

    max_flow_min_cut_core dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: stall on a pattern of its own, with free-running stretches
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready)
            sb.check_result('{node: m_axis_tdata[5:0], last: m_axis_tlast,
                              size: m_axis_tdata[12:6], flow: m_axis_tdata[68:13]});
        if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
        m_axis_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    // Hold valid high; set_graph drops it after the last register
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, val);
    endtask

    // Drive one word; bursts of random length with random gaps between them
    task automatic send_word(logic op, logic [5:0] a, logic [5:0] b, logic [31:0] w);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {4'd0, w, b, a};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(op, a, b, w);
    endtask

    // Drop valid, wait for every predicted word, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_graph(int n, int s, int t);
        write_cfg(CFG_NODE_COUNT, n[6:0]);
        write_cfg(CFG_SOURCE, s[6:0]);
        write_cfg(CFG_SINK, t[6:0]);
        i_cfg_valid <= 1'b0;
    endtask

    // Random graph: mostly edges inside range, small weights, then a run
    task automatic random_graph(int n, int edges);
        logic [31:0] w;
        for (int i = 0; i < edges; i++) begin
            case ($urandom_range(0, 9))
                0: w = $urandom();
                1: w = 32'hFFFF_FFFF;
                2: w = 0;
                default: w = $urandom_range(1, 20);
            endcase
            if ($urandom_range(0, 15) == 0)
                send_word(OP_EDGE, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), w);
            else
                send_word(OP_EDGE, 6'($urandom_range(0, n - 1)),
                          6'($urandom_range(0, n - 1)), w);
        end
        send_word(OP_RUN, 6'($urandom()), 6'($urandom()), $urandom());
    endtask

    initial begin
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: default config, parallel saturating edges, a path via node 63, a zero-weight edge
        send_word(OP_EDGE, 6'd0, 6'd1, 32'hFFFF_FFFF);
        send_word(OP_EDGE, 6'd0, 6'd1, 32'hFFFF_FFFF);
        send_word(OP_EDGE, 6'd0, 6'd63, 32'd5);
        send_word(OP_EDGE, 6'd63, 6'd1, 32'd3);
        send_word(OP_EDGE, 6'd1, 6'd0, 32'd0);
        send_word(OP_RUN, 6'd0, 6'd0, 32'd0);
        drain();

        // Narrow graph: edge beyond node range is ignored, sink beyond range
        set_graph(2, 0, 1);
        send_word(OP_EDGE, 6'd0, 6'd1, 32'd7);
        send_word(OP_EDGE, 6'd0, 6'd5, 32'd7);
        send_word(OP_RUN, 6'd63, 6'd63, 32'hFFFF_FFFF);
        drain();
        set_graph(4, 0, 9);
        send_word(OP_EDGE, 6'd0, 6'd2, 32'd1);
        send_word(OP_RUN, 6'd0, 6'd0, 32'd0);
        drain();

        // Source beyond range, source equal to sink, count clamped from 0 and 127
        set_graph(3, 5, 1);
        send_word(OP_RUN, 6'd0, 6'd0, 32'd0);
        drain();
        set_graph(0, 1, 1);
        send_word(OP_EDGE, 6'd1, 6'd0, 32'd4);
        send_word(OP_RUN, 6'd0, 6'd0, 32'd0);
        drain();
        set_graph(127, 63, 0);
        send_word(OP_EDGE, 6'd63, 6'd0, 32'd9);
        send_word(OP_EDGE, 6'd63, 6'd62, 32'h8000_0000);
        send_word(OP_EDGE, 6'd62, 6'd0, 32'hFFFF_FFFF);
        send_word(OP_RUN, 6'd0, 6'd0, 32'd0);
        drain();

        // Random phases; mostly small graphs, a few full-size ones
        for (int ph = 0; ph < 14; ph++) begin
            n = (ph % 5 == 4) ? 64 : $urandom_range(2, 10);
            set_graph(n, $urandom_range(0, n - 1), $urandom_range(0, n));
            random_graph(n, $urandom_range(4, 20));
            // Hold the sender until every cut word has come back
            drain();
        end

        if (sb.errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

    initial begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
